// ----- src/b64e_pkg.sv -----
// b64e_pkg: shared types, character constants and the alphabet lookup for the
// base64 stream encoder. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package b64e_pkg;

    localparam int unsigned CHARS_PER_JOB = 4;
    localparam int unsigned JOB_IDX_W     = $clog2(CHARS_PER_JOB);
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] PAD_CHAR   = 8'h3D;

    // position of the next byte inside its 3-byte group
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } t_phase;

    // one classified input byte: the characters it produces
    typedef struct packed {
        logic [CHARS_PER_JOB-1:0][7:0] chars;
        logic [JOB_IDX_W-1:0]          last_idx;
        logic                          fin;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] w;
        w = {2'b00, idx};
        if (idx < 6'd26) begin
            return 8'(CH_UPPER_A + w);
        end else if (idx < 6'd52) begin
            return 8'(CH_LOWER_A + w - 8'd26);
        end else if (idx < 6'd62) begin
            return 8'(CH_DIGIT_0 + w - 8'd52);
        end else if (idx == 6'd62) begin
            return CH_PLUS;
        end else begin
            return CH_SLASH;
        end
    endfunction

endpackage

// ----- src/b64e_front.sv -----
// b64e_front: accepts raw bytes, tracks group phase and leftover bits, and
// turns each byte into a job of one to four characters. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data,
    input  logic          i_final,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output b64e_pkg::t_job o_job
);
    import b64e_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    t_phase     grp_phase;
    logic [3:0] grp_carry;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_0;
            r_carry <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

    always_comb begin
        o_job          = '0;
        o_job.chars    = {CHARS_PER_JOB{PAD_CHAR}};
        o_job.fin      = i_final;
        grp_phase      = PH_1;
        grp_carry      = {2'b00, i_data[1:0]};

        unique case (r_phase)
            PH_1: begin
                o_job.chars[0] = b64_char({r_carry[1:0], i_data[7:4]});
                o_job.last_idx = JOB_IDX_W'(0);
                grp_carry      = i_data[3:0];
                grp_phase      = PH_2;
            end
            PH_2: begin
                o_job.chars[0] = b64_char({r_carry, i_data[7:6]});
                o_job.chars[1] = b64_char(i_data[5:0]);
                o_job.last_idx = JOB_IDX_W'(1);
                grp_carry      = 4'd0;
                grp_phase      = PH_0;
            end
            default: begin
                // phase 0, and the unused code acts the same
                o_job.chars[0] = b64_char(i_data[7:2]);
                o_job.last_idx = JOB_IDX_W'(0);
                grp_carry      = {2'b00, i_data[1:0]};
                grp_phase      = PH_1;
            end
        endcase

        // flush leftover bits left aligned, then pad to four characters
        if (i_final) begin
            if (grp_phase == PH_1) begin
                o_job.chars[1] = b64_char({grp_carry[1:0], 4'b0000});
                o_job.last_idx = JOB_IDX_W'(3);
            end else if (grp_phase == PH_2) begin
                o_job.chars[1] = b64_char({grp_carry, 2'b00});
                o_job.last_idx = JOB_IDX_W'(2);
            end
        end

        n_phase = r_phase;
        n_carry = r_carry;
        if (o_push) begin
            n_phase = i_final ? PH_0 : grp_phase;
            n_carry = i_final ? 4'd0 : grp_carry;
        end
    end

endmodule

// ----- src/b64e_queue.sv -----
// b64e_queue: short first-in first-out queue of jobs between the front and
// back parts. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output b64e_pkg::t_job o_job
);
    import b64e_pkg::*;

    t_job              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (i_pop && !i_push) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue count out of range");

endmodule

// ----- src/b64e_back.sv -----
// b64e_back: takes queued jobs and delivers their characters one per cycle, while
// ready, on the output channel with run and message end flags. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  b64e_pkg::t_job i_q_job,
    input  logic           i_ready,
    output logic           o_pop,
    output logic           o_valid,
    output logic [7:0]     o_char,
    output logic           o_run_last,
    output logic           o_message_end
);
    import b64e_pkg::*;

    logic                 r_busy;
    t_job                 r_job;
    logic [JOB_IDX_W-1:0] r_idx;
    logic                 at_last;

    assign at_last       = (r_idx == r_job.last_idx);
    assign o_valid       = r_busy;
    assign o_char        = r_job.chars[r_idx];
    assign o_run_last    = at_last;
    assign o_message_end = at_last && r_job.fin;
    assign o_pop         = i_q_valid && (!r_busy || (i_ready && at_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= JOB_IDX_W'(r_idx + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= r_job.last_idx))
        else $error("character index past end of job");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready) |=> (r_busy && r_idx == $past(r_idx)))
        else $error("character advanced while receiver stalled");
    a_idle_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && i_q_valid) |-> o_pop)
        else $error("back part idle with a job waiting");

endmodule

// ----- src/base64_stream_encoder_core.sv -----
// base64_stream_encoder_core: top level of the base64 stream encoder, joining
// the front classifier, the job queue and the character emitter. Depends on b64e_pkg.
`timescale 1ns / 1ps

// usage
//   input channel s_axis: one raw byte per transfer in tdata[7:0]; tlast marks
//   the final byte of a message, which flushes the leftover bits and pads
//   with '=' to a multiple of four characters
//   output channel m_axis: one ascii character per transfer in tdata[7:0];
//   tuser is high on the last character caused by one input byte, tlast on
//   the final character of the whole encoded message
// data path
//   an accepted byte's job is registered in the queue, then in the output stage
// throughput
//   the front takes one byte per cycle while the two-entry job queue has
//   room; the back emits one character per cycle while m_axis_tready is high,
//   so a byte yields one or two characters or (final byte) up to four, about
//   4/3 per byte on average, and the output port is what sets the sustained rate
// reset
//   synchronous active-low i_rst_n clears phase, leftover bits, queue and
//   the output stage; the next byte starts a new message
// stalls
//   when m_axis_tready is low the current character holds; the queue fills
//   and s_axis_tready drops once it is full

module base64_stream_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // final_byte
    // output channel
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tuser,   // [0] run_last
    output logic       m_axis_tlast    // message_end
);
    import b64e_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job front_job;
    t_job head_job;

    // classify each byte into a job of one to four characters
    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_data   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_job    (front_job)
    );

    // short queue decouples byte intake from character output
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // emit one character per transfer
    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_job       (head_job),
        .i_ready       (m_axis_tready),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .o_char        (m_axis_tdata),
        .o_run_last    (m_axis_tuser),
        .o_message_end (m_axis_tlast)
    );

endmodule
